// ===== rtl/kms_pkg.sv =====
package kms_pkg;

  localparam int ROW_LINES  = 4;
  localparam int COL_LINES  = 4;
  localparam int KEY_ID_W   = 5;
  localparam int ROW_IDS_W  = KEY_ID_W * COL_LINES;
  localparam int LOCKOUT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_IDS_W;
  localparam int ROW_IDX_W  = $clog2(ROW_LINES);
  localparam int COL_IDX_W  = $clog2(COL_LINES);

  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_IDS_ROW0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_IDS_ROW1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_IDS_ROW2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_IDS_ROW3  = 3'd4;

  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET   = 16'd300;
  localparam logic [ROW_IDS_W-1:0] KEY_IDS0_RESET  = 20'd3137;
  localparam logic [ROW_IDS_W-1:0] KEY_IDS1_RESET  = 20'd269521;
  localparam logic [ROW_IDS_W-1:0] KEY_IDS2_RESET  = 20'd404809;
  localparam logic [ROW_IDS_W-1:0] KEY_IDS3_RESET  = 20'd540109;

  typedef enum logic [1:0] {
    PH_SCANNING = 2'd0,
    PH_LOCKOUT  = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LOCKOUT_W-1:0]                 lockout_ticks;
    logic [ROW_LINES-1:0][ROW_IDS_W-1:0]  key_ids;
  } cfg_t;

  typedef struct packed {
    logic [COL_LINES-1:0] column_drive;
    logic                 key_valid;
    logic [KEY_ID_W-1:0]  key_code;
  } result_t;

  function automatic logic [KEY_ID_W-1:0] pick_id(logic [ROW_IDS_W-1:0] ids,
                                                  logic [COL_IDX_W-1:0] col);
    return ids[col*KEY_ID_W +: KEY_ID_W];
  endfunction

endpackage

// ===== rtl/kms_cfg_regs.sv =====
module kms_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0] cfg_data,
  output kms_pkg::cfg_t                 cfg
);
  import kms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_ticks <= LOCKOUT_RESET;
      cfg.key_ids[0]    <= KEY_IDS0_RESET;
      cfg.key_ids[1]    <= KEY_IDS1_RESET;
      cfg.key_ids[2]    <= KEY_IDS2_RESET;
      cfg.key_ids[3]    <= KEY_IDS3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCKOUT_TICKS: cfg.lockout_ticks <= cfg_data[LOCKOUT_W-1:0];
        REG_KEY_IDS_ROW0:  cfg.key_ids[0]    <= cfg_data;
        REG_KEY_IDS_ROW1:  cfg.key_ids[1]    <= cfg_data;
        REG_KEY_IDS_ROW2:  cfg.key_ids[2]    <= cfg_data;
        REG_KEY_IDS_ROW3:  cfg.key_ids[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/kms_scan_core.sv =====
module kms_scan_core #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [kms_pkg::ROW_LINES-1:0] row_levels,
  input  kms_pkg::cfg_t                 cfg,
  output kms_pkg::result_t              result
);
  import kms_pkg::*;

  phase_t                 phase, phase_next;
  logic [COL_IDX_W-1:0]   column_index, column_index_next;
  logic [ROW_IDX_W-1:0]   held_row, held_row_next;
  logic [KEY_ID_W-1:0]    latched_key, latched_key_next;
  logic [LOCKOUT_W-1:0]   lockout_count, lockout_count_next;

  logic [COL_IDX_W-1:0]   col;
  logic                   found;
  logic [ROW_IDX_W-1:0]   hit_row;
  logic [LOCKOUT_W-1:0]   count_dec;
  logic                   released;

  assign col = ({1'b0, column_index} >= (COL_IDX_W+1)'(COLUMNS)) ? '0 : column_index;
  assign count_dec = (lockout_count != '0) ? lockout_count - 1'b1 : lockout_count;
  assign released = row_levels[held_row];

  always_comb begin
    found   = 1'b0;
    hit_row = '0;
    for (int r = ROW_LINES - 1; r >= 0; r--) begin
      if (r < ROWS && !row_levels[r]) begin
        found   = 1'b1;
        hit_row = ROW_IDX_W'(r);
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    column_index_next  = col;
    held_row_next      = held_row;
    latched_key_next   = latched_key;
    lockout_count_next = lockout_count;
    case (phase)
      PH_LOCKOUT: begin
        lockout_count_next = count_dec;
        if (count_dec == '0) phase_next = PH_RELEASE;
      end
      PH_RELEASE: begin
        if (released) begin
          column_index_next = '0;
          phase_next        = PH_SCANNING;
        end
      end
      default: begin
        if (found) begin
          held_row_next      = hit_row;
          latched_key_next   = pick_id(cfg.key_ids[hit_row], col);
          lockout_count_next = cfg.lockout_ticks;
          phase_next = (cfg.lockout_ticks == '0) ? PH_RELEASE : PH_LOCKOUT;
        end else begin
          phase_next = PH_SCANNING;
          if ({1'b0, col} + 1'b1 >= (COL_IDX_W+1)'(COLUMNS)) column_index_next = '0;
          else column_index_next = col + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    result.column_drive = ~(COL_LINES'(1) << column_index_next);
    result.key_valid    = (phase == PH_RELEASE) && released;
    result.key_code     = result.key_valid ? latched_key : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SCANNING;
      column_index  <= '0;
      held_row      <= '0;
      latched_key   <= '0;
      lockout_count <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      column_index  <= column_index_next;
      held_row      <= held_row_next;
      latched_key   <= latched_key_next;
      lockout_count <= lockout_count_next;
    end
  end

  a_release_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_RELEASE && released
    |=> phase == PH_SCANNING && column_index == '0)
    else $error("release did not restart scan at column 0");

  a_press_loads_lockout: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_SCANNING && found && cfg.lockout_ticks != '0
    |=> phase == PH_LOCKOUT && lockout_count == $past(cfg.lockout_ticks))
    else $error("press did not load lockout count");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(column_index) && $stable(lockout_count))
    else $error("scan state moved without a word");

  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_index} < (COL_IDX_W+1)'(COLUMNS))
    else $error("column index out of range");

endmodule

// ===== rtl/keypad_matrix_scanner.sv =====
// Keypad matrix scanner, one scan tick per word.
// Input channel (in_valid/in_ready, row_levels): one word per tick, the row
// lines sampled while the current column is driven low (0 = pressed).
// Output channel (out_valid/out_ready): one word per input word with
// column_drive for the next tick, and key_valid/key_code when a key was
// released on that tick.
// Config port (cfg_we, cfg_index, cfg_data): index 0 lockout ticks, 1..4 key
// ID rows 0..3; write only while no word is in flight.
// An accepted word goes to the input register, its result to the result
// register. Throughput: one word per cycle while the receiver keeps up; the
// scan state update is a single pass of logic between those registers.
// Reset: scanner returns to scanning at column 0 and the config registers
// take their default values; no words are held.
// Receiver stall: the result register holds, the input register fills, and
// in_ready drops once both are occupied; no word is lost or repeated.
module keypad_matrix_scanner #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kms_pkg::ROW_LINES-1:0]  row_levels,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kms_pkg::COL_LINES-1:0]  column_drive,
  output logic                           key_valid,
  output logic [kms_pkg::KEY_ID_W-1:0]   key_code,
  input  logic                           cfg_we,
  input  logic [kms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kms_pkg::*;

  cfg_t                 cfg;
  result_t              result;
  logic                 stage_valid;
  logic [ROW_LINES-1:0] stage_rows;
  logic                 advance;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  kms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kms_scan_core #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .row_levels (stage_rows),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stage_rows <= row_levels;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      column_drive <= result.column_drive;
      key_valid    <= result.key_valid;
      key_code     <= result.key_code;
    end
  end

endmodule
